// ===== hdl/css_pkg.sv =====
// Shared types and constants for the counting sort store.
`default_nettype none

package css_pkg;

    localparam int VW             = 16;   // value and sorted_value width
    localparam int CNT_W          = 8;    // bin count width
    localparam int DEF_VALUE_RANGE = 256;
    localparam int DEF_MAX_ITEMS  = 255;

    localparam logic [CNT_W-1:0] BIN_MAX = '1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic       clr_wr;      // clear one bin, advance clear address
        logic       load_in;     // capture the accepted input transfer
        logic       rd_val;      // read bin of the input value
        logic       rd_cur;      // read bin at the scan cursor
        logic       ins_wr;      // commit insert
        logic       take_hit;    // commit take from the cursor bin
        logic       cur_inc;     // advance scan cursor
        logic       res_set;     // load a flagged result
        logic [1:0] res_status;
        logic       push_out;    // move pending result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic cmd_take;
        logic in_range;
        logic total_full;
        logic total_zero;
        logic bin_full;
        logic bin_zero;
        logic cursor_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/css_datapath.sv =====
// Datapath of the counting sort store: bin memory, totals, cursor, result registers.
`default_nettype none

module css_datapath
    import css_pkg::*;
#(
    parameter int VALUE_RANGE = DEF_VALUE_RANGE,
    parameter int MAX_ITEMS   = DEF_MAX_ITEMS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    output t_stat              o_stat,
    input  wire logic [VW-1:0] i_in_value,
    input  wire logic          i_in_command,
    input  wire logic          i_m_tready,
    output logic               o_m_tvalid,
    output logic [VW-1:0]      o_sorted_value,
    output logic [1:0]         o_status
);

    localparam int AW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
    localparam int TW = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0] mem [VALUE_RANGE];

    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_cmd;
    logic [VW-1:0]    r_val;
    logic [TW-1:0]    r_total, n_total;
    logic [AW-1:0]    r_cursor, n_cursor;
    logic [CNT_W-1:0] r_rdata;
    logic [VW-1:0]    r_res_value;
    logic [1:0]       r_res_status;
    logic             r_out_valid, n_out_valid;
    logic [VW-1:0]    r_out_value;
    logic [1:0]       r_out_status;

    logic             w_en;
    logic [AW-1:0]    w_addr;
    logic [CNT_W-1:0] w_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    val_idx;

    assign val_idx = r_val[AW-1:0];

    always_comb begin
        w_en   = i_cmd.clr_wr | i_cmd.ins_wr | i_cmd.take_hit;
        w_addr = r_clr_addr;
        w_data = '0;
        if (i_cmd.ins_wr) begin
            w_addr = val_idx;
            w_data = r_rdata + CNT_W'(1);
        end else if (i_cmd.take_hit) begin
            w_addr = r_cursor;
            w_data = r_rdata - CNT_W'(1);
        end
        rd_en   = i_cmd.rd_val | i_cmd.rd_cur;
        rd_addr = i_cmd.rd_val ? val_idx : r_cursor;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_total    = r_total;
        n_cursor   = r_cursor;
        if (i_cmd.clr_wr) begin
            n_clr_addr = r_clr_addr + AW'(1);
        end
        if (i_cmd.ins_wr) begin
            n_total = r_total + TW'(1);
            if (val_idx < r_cursor) begin
                n_cursor = val_idx;
            end
        end else if (i_cmd.take_hit) begin
            n_total = r_total - TW'(1);
            // last item gone: restart scans from the bottom
            if (r_total == TW'(1)) begin
                n_cursor = '0;
            end
        end else if (i_cmd.cur_inc) begin
            n_cursor = r_cursor + AW'(1);
        end
        n_out_valid = r_out_valid;
        if (i_cmd.push_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_addr  <= n_clr_addr;
            r_total     <= n_total;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_in_command;
            r_val <= i_in_value;
        end
        if (i_cmd.res_set) begin
            r_res_value  <= '0;
            r_res_status <= i_cmd.res_status;
        end else if (i_cmd.ins_wr) begin
            r_res_value  <= '0;
            r_res_status <= ST_OK;
        end else if (i_cmd.take_hit) begin
            r_res_value  <= VW'(r_cursor);
            r_res_status <= ST_OK;
        end
        if (i_cmd.push_out) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    always_comb begin
        o_stat.clr_last    = (r_clr_addr == AW'(VALUE_RANGE - 1));
        o_stat.cmd_take    = (r_cmd == CMD_TAKE);
        o_stat.in_range    = ({1'b0, r_val} < (VW + 1)'(VALUE_RANGE));
        o_stat.total_full  = (r_total >= TW'(MAX_ITEMS));
        o_stat.total_zero  = (r_total == '0);
        o_stat.bin_full    = (r_rdata == BIN_MAX);
        o_stat.bin_zero    = (r_rdata == '0);
        o_stat.cursor_last = (r_cursor == AW'(VALUE_RANGE - 1));
        o_stat.out_free    = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_status       = r_out_status;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(MAX_ITEMS))
        else $error("stored total above limit");

    a_take_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_hit |-> (r_rdata != '0) && (r_total != '0))
        else $error("take from an empty bin");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |-> (r_rdata != BIN_MAX) && (r_total < TW'(MAX_ITEMS)))
        else $error("insert into a full bin or store");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_out |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// ===== hdl/css_ctrl.sv =====
// Controller state machine of the counting sort store.
`default_nettype none

module css_ctrl
    import css_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_EXEC     = 7'b0000100,
        S_INS_CHK  = 7'b0001000,
        S_TAKE_CHK = 7'b0010000,
        S_TAKE_RD  = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.cmd_take) begin
                    if (!i_stat.in_range) begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_RANGE;
                        n_state          = S_FIN;
                    end else if (i_stat.total_full) begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_FIN;
                    end else begin
                        o_cmd.rd_val = 1'b1;
                        n_state      = S_INS_CHK;
                    end
                end else if (i_stat.total_zero) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_EMPTY;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_TAKE_CHK;
                end
            end
            S_INS_CHK: begin
                if (i_stat.bin_full) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_FULL;
                end else begin
                    o_cmd.ins_wr = 1'b1;
                end
                n_state = S_FIN;
            end
            S_TAKE_CHK: begin
                if (!i_stat.bin_zero) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = S_FIN;
                end else if (i_stat.cursor_last) begin
                    // scan ran off the top: report as empty
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_EMPTY;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.cur_inc = 1'b1;
                    n_state       = S_TAKE_RD;
                end
            end
            S_TAKE_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = S_TAKE_CHK;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.push_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/counting_sort_store.sv =====
// Top level of the counting sort store.
//
// Slave stream: tuser = command (0 insert, 1 take), tdata = value (16 bits).
// Master stream: tdata = sorted_value (16 bits), tuser = status
// (0 ok, 1 take while empty, 2 value out of range, 3 store full).
// Every input transfer yields exactly one output transfer, in order.
// An insert adds one to its value's bin; a take returns and removes the
// smallest stored value.
// One item is worked at a time. Insert and full-bin insert pass the execute,
// insert check and final states; a take of a filled cursor bin passes the
// execute, take check and final states. Flagged range, full-total and empty
// cases go straight from the execute to the final state. Output valid and
// next input ready come in the same cycle. A take adds a take read and a
// take check state per empty bin the cursor steps over, as each step is a
// registered read of the bin memory. After reset the bin memory is cleared
// one bin per cycle with tready low. A stalled output holds its result in
// the output register while one more item is worked; that item's result
// then waits in the final state, with tready low, until the output transfer.
`default_nettype none

module counting_sort_store
    import css_pkg::*;
#(
    parameter int VALUE_RANGE = DEF_VALUE_RANGE,
    parameter int MAX_ITEMS   = DEF_MAX_ITEMS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [15:0]   i_s_tdata,   // [15:0] value
    input  wire logic          i_s_tuser,   // [0] command
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [15:0]        o_m_tdata,   // [15:0] sorted_value
    output logic [1:0]         o_m_tuser    // [1:0] status
);

    t_cmd  cmd;
    t_stat stat;

    css_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    css_datapath #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_ITEMS   (MAX_ITEMS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_in_value     (i_s_tdata),
        .i_in_command   (i_s_tuser),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_sorted_value (o_m_tdata),
        .o_status       (o_m_tuser)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the counting sort store: inserts, takes and flagged cases.
module tb_top;
    import css_pkg::*;

    localparam int VALUE_RANGE  = DEF_VALUE_RANGE;
    localparam int MAX_ITEMS    = DEF_MAX_ITEMS;
    localparam int ITEM_GOAL    = 440;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic          cmd;
        logic [VW-1:0] value;
    } store_cmd_t;

    typedef struct packed {
        logic [VW-1:0] sorted_value;
        logic [1:0]    status;
    } sort_result_t;

    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          s_tvalid = 1'b0;
    logic [VW-1:0] s_tdata  = '0;    // [15:0] value
    logic          s_tuser  = 1'b0;  // [0] command
    logic          m_tready = 1'b0;
    wire           s_tready;
    wire           m_tvalid;
    wire  [VW-1:0] m_tdata;          // [15:0] sorted_value
    wire  [1:0]    m_tuser;          // [1:0] status

    store_cmd_t   store_cmds_q[$];
    sort_result_t sort_results_q[$];

    // predictor state
    logic [CNT_W-1:0] bin_model[VALUE_RANGE];
    int unsigned      stored_model = 0;
    int unsigned      cursor_model = 0;

    int item_total   = 0;
    int n_accepted   = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int gen_level    = 0;
    int hold_left    = 0;
    int hold_last_at = -1;
    int send_idle;
    int recv_idle;
    logic [1:0]   idle_phase;
    sort_result_t want;

    counting_sort_store #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_ITEMS   (MAX_ITEMS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic sort_result_t sort_store_apply(store_cmd_t c);
        sort_result_t r;
        int unsigned  i;
        r.sorted_value = '0;
        r.status       = ST_OK;
        if (c.cmd == CMD_INSERT) begin
            if (c.value >= VALUE_RANGE) begin
                r.status = ST_RANGE;
            end else if (stored_model >= MAX_ITEMS || bin_model[c.value] == BIN_MAX) begin
                r.status = ST_FULL;
            end else begin
                bin_model[c.value] = bin_model[c.value] + 1'b1;
                stored_model++;
                if (c.value < cursor_model)
                    cursor_model = c.value;
            end
        end else if (stored_model == 0) begin
            r.status = ST_EMPTY;
        end else begin
            i = cursor_model;
            while (i < VALUE_RANGE && bin_model[i] == 0)
                i++;
            if (i >= VALUE_RANGE) begin
                r.status = ST_EMPTY;
            end else begin
                bin_model[i] = bin_model[i] - 1'b1;
                stored_model--;
                cursor_model   = (stored_model == 0) ? 0 : i;
                r.sorted_value = i[VW-1:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (fail_count < PRINT_CAP)
            $display("MISMATCH @%0d: %s", cycle_count, what);
        fail_count++;
    endtask

    // queue one command; gen_level roughly tracks fill so sequences can be shaped
    task automatic push_cmd(logic cmd, int unsigned value);
        store_cmd_t c;
        c.cmd   = cmd;
        c.value = value[VW-1:0];
        store_cmds_q.push_back(c);
        if (cmd == CMD_INSERT && value < VALUE_RANGE && gen_level < MAX_ITEMS)
            gen_level++;
        else if (cmd == CMD_TAKE && gen_level > 0)
            gen_level--;
    endtask

    function automatic int unsigned pick_value(int unsigned base);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return base + $urandom_range(15);
        else if (roll < 90)
            return $urandom_range(VALUE_RANGE - 1);
        else
            return $urandom_range(65535, VALUE_RANGE);
    endfunction

    assign idle_phase = (3 * n_accepted < item_total)     ? 2'd0 :
                        (3 * n_accepted < 2 * item_total) ? 2'd1 : 2'd2;
    assign send_idle  = (idle_phase == 2'd0) ? 9  : (idle_phase == 2'd1) ? 79 : 0;
    assign recv_idle  = (idle_phase == 2'd0) ? 79 : (idle_phase == 2'd1) ? 9  : 0;

    // input driver: the item in flight stays at the head of store_cmds_q until its transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sort_results_q.push_back(sort_store_apply(store_cmds_q.pop_front()));
                n_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (store_cmds_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= store_cmds_q[0].value;
                    s_tuser  <= store_cmds_q[0].cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off, so the block keeps its result and stalls its input
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((n_accepted == 30 || n_accepted == item_total * 5 / 6)
                     && hold_last_at != n_accepted) begin
            hold_left    <= HOLD_CYCLES;
            hold_last_at <= n_accepted;
        end
    end

    // output monitor and checker
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sort_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer value %0d status %0d",
                                              m_tdata, m_tuser));
                end else begin
                    want = sort_results_q.pop_front();
                    if (m_tdata !== want.sorted_value)
                        report_mismatch($sformatf("sorted_value %0d, want %0d",
                                                  m_tdata, want.sorted_value));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_tuser, want.status));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("counting_sort_store test failed");
            $finish;
        end
    end

    initial begin
        int  n;
        int  base;
        bit  filled;
        filled = 1'b0;
        foreach (bin_model[k])
            bin_model[k] = '0;

        // directed: empty take, range edges, cursor moving down, value bit patterns
        push_cmd(CMD_TAKE,   16'hFFFF);
        push_cmd(CMD_INSERT, 0);
        push_cmd(CMD_INSERT, VALUE_RANGE - 1);
        push_cmd(CMD_INSERT, VALUE_RANGE);
        push_cmd(CMD_INSERT, 16'hFFFF);
        push_cmd(CMD_INSERT, 16'h8000);
        push_cmd(CMD_INSERT, 128);
        push_cmd(CMD_INSERT, 128);
        push_cmd(CMD_TAKE,   16'h0000);
        push_cmd(CMD_TAKE,   16'h0001);
        push_cmd(CMD_INSERT, 5);
        push_cmd(CMD_TAKE,   16'h5555);
        push_cmd(CMD_TAKE,   16'hAAAA);
        push_cmd(CMD_TAKE,   16'h00FF);
        push_cmd(CMD_TAKE,   16'hFF00);
        push_cmd(CMD_INSERT, 16'h0055);
        push_cmd(CMD_INSERT, 16'h00AA);
        push_cmd(CMD_INSERT, 16'h5555);
        push_cmd(CMD_INSERT, 16'hAAAA);
        push_cmd(CMD_TAKE,   16'h7FFF);
        push_cmd(CMD_TAKE,   16'h8001);
        push_cmd(CMD_TAKE,   0);

        while (store_cmds_q.size() < ITEM_GOAL) begin
            if (!filled && store_cmds_q.size() >= 100) begin
                // fill to the item limit, then knock on the full store
                filled = 1'b1;
                base   = $urandom_range(VALUE_RANGE - 64);
                while (gen_level < MAX_ITEMS)
                    push_cmd(CMD_INSERT, ($urandom_range(3) == 0) ?
                             $urandom_range(VALUE_RANGE - 1) : base + $urandom_range(63));
                push_cmd(CMD_INSERT, base);
                push_cmd(CMD_INSERT, 0);
                push_cmd(CMD_INSERT, 16'hFFFF);
                push_cmd(CMD_INSERT, VALUE_RANGE - 1);
                repeat (60) push_cmd(CMD_TAKE, $urandom_range(65535));
            end else if ($urandom_range(9) == 0) begin
                repeat (8) push_cmd(1'($urandom_range(1)), $urandom_range(65535));
            end else begin
                n    = $urandom_range(30, 1);
                base = $urandom_range(VALUE_RANGE - 16);
                repeat (n) push_cmd(CMD_INSERT, pick_value(base));
                repeat (n + $urandom_range(2)) push_cmd(CMD_TAKE, $urandom_range(65535));
            end
        end
        item_total = store_cmds_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (store_cmds_q.size() != 0 || sort_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("counting_sort_store test passed");
        else
            $display("counting_sort_store test failed");
        $finish;
    end

endmodule
